// ----- hdl/qra_pkg.sv -----
// Package for the quaternion body-to-world acceleration rotator.
// Widths, fixed-point constants and the saturating round used by the pipeline.
// No dependencies.
package qra_pkg;

  localparam int ACC_W  = 24;   // Q7.16 body acceleration
  localparam int QUAT_W = 15;   // Q1.14 quaternion component
  localparam int OUT_W  = 26;   // Q9.16 world acceleration
  localparam int GRAV_W = 21;   // Q.16 gravity, unsigned

  localparam int QQ_W   = 2 * QUAT_W;       // quaternion product, Q.28
  localparam int MAT_W  = 32;               // matrix entry, Q.28, |r| <= 2^30
  localparam int MUL_W  = MAT_W + ACC_W;    // entry times vector component, Q.44
  localparam int SUM_W  = 60;               // three products less gravity, Q.44

  localparam int MAT_FRAC = 28;

  localparam logic [GRAV_W-1:0] GRAV_RESET = GRAV_W'(642908);

  localparam logic signed [MAT_W-1:0] MAT_ONE = MAT_W'(1) <<< MAT_FRAC;
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (MAT_FRAC - 1);

  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -(SUM_W'(1) <<< (OUT_W - 1));

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [OUT_W-1:0]  wacc_t;
  typedef logic        [GRAV_W-1:0] grav_t;
  typedef logic signed [QQ_W-1:0]   qq_t;
  typedef logic signed [MAT_W-1:0]  mat_t;
  typedef logic signed [MUL_W-1:0]  mul_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Q.44 to Q.16, nearest with ties towards plus infinity, clamped to OUT_W bits.
  function automatic wacc_t round_sat(input sum_t v);
    sum_t t;
    sum_t r;
    begin
      t = v + RND_HALF;
      r = t >>> MAT_FRAC;
      if (r > OUT_MAX) begin
        r = OUT_MAX;
      end else if (r < OUT_MIN) begin
        r = OUT_MIN;
      end
      round_sat = r[OUT_W-1:0];
    end
  endfunction

endpackage

// ----- hdl/qra_in_if.sv -----
// Input channel of the rotator: body acceleration and attitude quaternion.
// Depends on qra_pkg.
interface qra_in_if;
  import qra_pkg::*;

  logic  valid;
  logic  ready;
  acc_t  accel_body_x;
  acc_t  accel_body_y;
  acc_t  accel_body_z;
  quat_t quat_w;
  quat_t quat_x;
  quat_t quat_y;
  quat_t quat_z;

  modport source (output valid, accel_body_x, accel_body_y, accel_body_z,
                  output quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, accel_body_x, accel_body_y, accel_body_z,
                  input quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ----- hdl/qra_out_if.sv -----
// Result channel of the rotator: world-frame acceleration, gravity removed from z.
// Depends on qra_pkg.
interface qra_out_if;
  import qra_pkg::*;

  logic  valid;
  logic  ready;
  wacc_t world_acc_x;
  wacc_t world_acc_y;
  wacc_t world_acc_z;

  modport source (output valid, world_acc_x, world_acc_y, world_acc_z, input ready);
  modport sink   (input valid, world_acc_x, world_acc_y, world_acc_z, output ready);
endinterface

// ----- hdl/quaternion_rotate_accel_to_world.sv -----
// Top level of the quaternion body-to-world acceleration rotator.
// Depends on qra_pkg, qra_in_if and qra_out_if.
//
// Rotates a Q7.16 body acceleration by the rotation matrix of a Q1.14
// quaternion (not normalised), subtracts cfg gravity from world z, rounds
// once to Q9.16 (ties up) and saturates. One beat is taken per clock
// unless the pipeline holds. Quaternion products, matrix entries,
// entry-by-component products, row sums and round/saturate each own one
// register stage, in that order. The whole pipeline advances together and
// holds while the output register is full and not taken, so in_bus.ready
// follows out_bus.ready combinationally. Gravity is read at the row-sum
// stage; write it only while the pipeline is empty.
module quaternion_rotate_accel_to_world (
  input  logic                  clk,
  input  logic                  rst_n,
  qra_in_if.sink                in_bus,
  qra_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  qra_pkg::grav_t        cfg_wdata
);
  import qra_pkg::*;

  logic  adv;
  grav_t grav_r;

  // stage 1: quaternion products
  logic  v1_r;
  acc_t  ax1_r, ay1_r, az1_r;
  qq_t   xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, xw_r, yw_r, zw_r;
  // stage 2: matrix
  logic  v2_r;
  acc_t  ax2_r, ay2_r, az2_r;
  mat_t  m_r [9];
  // stage 3: products
  logic  v3_r;
  mul_t  p_r [9];
  // stage 4: row sums
  logic  v4_r;
  sum_t  wx_r, wy_r, wz_r;
  // output register
  logic  vo_r;
  wacc_t ox_r, oy_r, oz_r;

  assign adv          = !vo_r || out_bus.ready;
  assign in_bus.ready = adv;

  assign out_bus.valid       = vo_r;
  assign out_bus.world_acc_x = ox_r;
  assign out_bus.world_acc_y = oy_r;
  assign out_bus.world_acc_z = oz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= GRAV_RESET;
    end else if (cfg_we) begin
      grav_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_bus.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vo_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax1_r <= in_bus.accel_body_x;
      ay1_r <= in_bus.accel_body_y;
      az1_r <= in_bus.accel_body_z;
      xx_r  <= in_bus.quat_x * in_bus.quat_x;
      yy_r  <= in_bus.quat_y * in_bus.quat_y;
      zz_r  <= in_bus.quat_z * in_bus.quat_z;
      xy_r  <= in_bus.quat_x * in_bus.quat_y;
      xz_r  <= in_bus.quat_x * in_bus.quat_z;
      yz_r  <= in_bus.quat_y * in_bus.quat_z;
      xw_r  <= in_bus.quat_x * in_bus.quat_w;
      yw_r  <= in_bus.quat_y * in_bus.quat_w;
      zw_r  <= in_bus.quat_z * in_bus.quat_w;

      ax2_r <= ax1_r;
      ay2_r <= ay1_r;
      az2_r <= az1_r;
      m_r[0] <= MAT_ONE - ((MAT_W'(yy_r) + MAT_W'(zz_r)) <<< 1);
      m_r[1] <= (MAT_W'(xy_r) - MAT_W'(zw_r)) <<< 1;
      m_r[2] <= (MAT_W'(xz_r) + MAT_W'(yw_r)) <<< 1;
      m_r[3] <= (MAT_W'(xy_r) + MAT_W'(zw_r)) <<< 1;
      m_r[4] <= MAT_ONE - ((MAT_W'(xx_r) + MAT_W'(zz_r)) <<< 1);
      m_r[5] <= (MAT_W'(yz_r) - MAT_W'(xw_r)) <<< 1;
      m_r[6] <= (MAT_W'(xz_r) - MAT_W'(yw_r)) <<< 1;
      m_r[7] <= (MAT_W'(yz_r) + MAT_W'(xw_r)) <<< 1;
      m_r[8] <= MAT_ONE - ((MAT_W'(xx_r) + MAT_W'(yy_r)) <<< 1);

      p_r[0] <= m_r[0] * ax2_r;
      p_r[1] <= m_r[1] * ay2_r;
      p_r[2] <= m_r[2] * az2_r;
      p_r[3] <= m_r[3] * ax2_r;
      p_r[4] <= m_r[4] * ay2_r;
      p_r[5] <= m_r[5] * az2_r;
      p_r[6] <= m_r[6] * ax2_r;
      p_r[7] <= m_r[7] * ay2_r;
      p_r[8] <= m_r[8] * az2_r;

      wx_r <= SUM_W'(p_r[0]) + SUM_W'(p_r[1]) + SUM_W'(p_r[2]);
      wy_r <= SUM_W'(p_r[3]) + SUM_W'(p_r[4]) + SUM_W'(p_r[5]);
      // gravity is unsigned Q.16; align to Q.44
      wz_r <= SUM_W'(p_r[6]) + SUM_W'(p_r[7]) + SUM_W'(p_r[8])
            - (sum_t'({1'b0, grav_r}) <<< MAT_FRAC);

      ox_r <= round_sat(wx_r);
      oy_r <= round_sat(wy_r);
      oz_r <= round_sat(wz_r);
    end
  end

endmodule

// ----- hdl/qra_checker.sv -----
// Port-level checks for the rotator, bound to the top level.
// Depends on quaternion_rotate_accel_to_world and its interfaces.
module qra_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [25:0] out_x,
  input logic [25:0] out_z
);

  // held result beat stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_z))
    else $error("result payload changed while stalled");

  // pipeline only stalls on a full, untaken output register
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input refused with room in pipeline");

  // accepted beat reaches the output register when the sink keeps taking beats
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
    |=> out_valid)
    else $error("accepted beat did not emerge on time");

endmodule

bind quaternion_rotate_accel_to_world qra_checker u_qra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_x     (out_bus.world_acc_x),
  .out_z     (out_bus.world_acc_z)
);
